[sv/ycbcr_to_rgb_converter_core_defines.svh]
// Assertion macros shared by the checker of the YCbCr to RGB converter.
`ifndef YCBCR_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define YCBCR_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define YRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define YRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/yrc_pkg.sv]
// Package with constants and lookup-table builders for the YCbCr to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package yrc_pkg;

  localparam int FRACTION_BITS_DEF = 18;
  localparam int SAMPLE_W          = 8;
  localparam int ROM_DEPTH         = 2 ** SAMPLE_W;

  localparam int LUMA_MIN   = 16;
  localparam int LUMA_MAX   = 235;
  localparam int CHROMA_MIN = 16;
  localparam int CHROMA_MAX = 240;
  localparam int CHROMA_MID = 128;

  // Coefficients in millionths.
  localparam int unsigned COEF_R_CR = 1402000;
  localparam int unsigned COEF_G_CR = 714136;
  localparam int unsigned COEF_G_CB = 344136;
  localparam int unsigned COEF_B_CB = 1772000;

  localparam longint unsigned LUMA_DEN   = 219;
  localparam longint unsigned CHROMA_DEN = 224000000;
  localparam longint unsigned FULL_SCALE = 255;

  function automatic int clip_code(input int code, input int lo, input int hi);
    int r;
    r = code;
    if (code < lo) r = lo;
    if (code > hi) r = hi;
    return r;
  endfunction

  // Luma term: round((Y - 16) * 255/219 * 2^frac) + 2^(frac-1), Y clipped first.
  function automatic longint luma_term(input int code, input int frac);
    longint unsigned y;
    longint unsigned num;
    longint unsigned m;
    y   = longint'(clip_code(code, LUMA_MIN, LUMA_MAX));
    num = ((y - longint'(LUMA_MIN)) * FULL_SCALE) << frac;
    m   = (2 * num + LUMA_DEN) / (2 * LUMA_DEN);
    return longint'(m + (64'd1 << (frac - 1)));
  endfunction

  // Chroma term: round(k * (C - 128) * 255/224 * 2^frac), half away from zero.
  function automatic longint chroma_term(input int unsigned coef_micro, input bit coef_neg,
                                         input int code, input int frac);
    int              d;
    bit              neg;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned m;
    d   = clip_code(code, CHROMA_MIN, CHROMA_MAX) - CHROMA_MID;
    neg = coef_neg;
    if (d < 0) begin
      neg = !neg;
      mag = longint'(-d);
    end else begin
      mag = longint'(d);
    end
    num = (longint'(coef_micro) * mag * FULL_SCALE) << frac;
    m   = (2 * num + CHROMA_DEN) / (2 * CHROMA_DEN);
    return neg ? -longint'(m) : longint'(m);
  endfunction

endpackage

`default_nettype wire

[sv/ycbcr_to_rgb_converter_core.sv]
// Top level of the limited-range BT.601 YCbCr to RGB pixel converter.
//
// Channel   Ports                                    Handshake
// -------   -----------------------------------      ------------------------------
// pixel in  luma, blue_diff, red_diff, frame_end     start high, busy low at clk edge
// pixel out red, green, blue, frame_last             done high for one cycle
//
// Every pixel transaction passes the input register, then the table lookups,
// the two- and three-term sums and saturation, then the result register. A new
// pixel is accepted on every clock edge outside reset, so the sustained rate is
// one pixel per cycle. busy is high only during reset. The reset is synchronous
// and clears only the valid flags of the two registers. The receiver cannot
// stall; done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module ycbcr_to_rgb_converter_core
  import yrc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] luma,
  input  logic [SAMPLE_W-1:0] blue_diff,
  input  logic [SAMPLE_W-1:0] red_diff,
  input  logic                frame_end,
  output logic                done,
  output logic [SAMPLE_W-1:0] red,
  output logic [SAMPLE_W-1:0] green,
  output logic [SAMPLE_W-1:0] blue,
  output logic                frame_last
);

  // Each term stays below 2^(FRACTION_BITS+8) in magnitude; three of them
  // summed need two more bits.
  localparam int TERM_W = FRACTION_BITS + 9;
  localparam int SUM_W  = FRACTION_BITS + 11;

  // Constant lookup tables, indexed by the raw 8-bit sample. The clipping
  // of out-of-range codes is folded into the table contents, including the
  // green Cb term, which clips above 240 like the other chroma terms.
  logic signed [TERM_W-1:0] y_rom   [ROM_DEPTH];
  logic signed [TERM_W-1:0] r_cr_rom[ROM_DEPTH];
  logic signed [TERM_W-1:0] g_cr_rom[ROM_DEPTH];
  logic signed [TERM_W-1:0] g_cb_rom[ROM_DEPTH];
  logic signed [TERM_W-1:0] b_cb_rom[ROM_DEPTH];

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    assign y_rom[i]    = TERM_W'(luma_term(i, FRACTION_BITS));
    assign r_cr_rom[i] = TERM_W'(chroma_term(COEF_R_CR, 1'b0, i, FRACTION_BITS));
    assign g_cr_rom[i] = TERM_W'(chroma_term(COEF_G_CR, 1'b1, i, FRACTION_BITS));
    assign g_cb_rom[i] = TERM_W'(chroma_term(COEF_G_CB, 1'b1, i, FRACTION_BITS));
    assign b_cb_rom[i] = TERM_W'(chroma_term(COEF_B_CB, 1'b0, i, FRACTION_BITS));
  end

  // Input register.
  logic                in_valid;
  logic [SAMPLE_W-1:0] luma_q;
  logic [SAMPLE_W-1:0] cb_q;
  logic [SAMPLE_W-1:0] cr_q;
  logic                frame_end_q;
  logic                accept;

  // The block is never held off except while reset is applied.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      luma_q      <= luma;
      cb_q        <= blue_diff;
      cr_q        <= red_diff;
      frame_end_q <= frame_end;
    end
  end

  // Floor shift by the fraction width, then clamp to 0..255. A negative sum
  // always floors to a negative pixel, so the sign bit alone selects zero.
  function automatic logic [SAMPLE_W-1:0] to_pixel(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    logic [SAMPLE_W-1:0]     p;
    q = s >>> FRACTION_BITS;
    if (s[SUM_W-1]) begin
      p = '0;
    end else if (q[SUM_W-1:SAMPLE_W] != '0) begin
      p = '1;
    end else begin
      p = q[SAMPLE_W-1:0];
    end
    return p;
  endfunction

  logic signed [SUM_W-1:0] red_sum;
  logic signed [SUM_W-1:0] green_sum;
  logic signed [SUM_W-1:0] blue_sum;
  logic [SAMPLE_W-1:0]     red_next;
  logic [SAMPLE_W-1:0]     green_next;
  logic [SAMPLE_W-1:0]     blue_next;

  always_comb begin
    red_sum    = SUM_W'(y_rom[luma_q]) + SUM_W'(r_cr_rom[cr_q]);
    green_sum  = SUM_W'(y_rom[luma_q]) + SUM_W'(g_cb_rom[cb_q]) + SUM_W'(g_cr_rom[cr_q]);
    blue_sum   = SUM_W'(y_rom[luma_q]) + SUM_W'(b_cb_rom[cb_q]);
    red_next   = to_pixel(red_sum);
    green_next = to_pixel(green_sum);
    blue_next  = to_pixel(blue_sum);
  end

  // Result register: done marks the single cycle a result is on the ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
      frame_last <= frame_end_q;
    end
  end

endmodule

`default_nettype wire

[sv/yrc_checker.sv]
// Port-level checker for the YCbCr to RGB converter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "ycbcr_to_rgb_converter_core_defines.svh"

module yrc_checker
  import yrc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [SAMPLE_W-1:0] blue_diff,
  input logic [SAMPLE_W-1:0] red_diff,
  input logic                frame_end,
  input logic                done,
  input logic [SAMPLE_W-1:0] red,
  input logic [SAMPLE_W-1:0] green,
  input logic [SAMPLE_W-1:0] blue,
  input logic                frame_last
);

  logic took;
  logic neutral;
  logic gray;
  logic gray_due;
  assign took     = start && !busy;
  assign neutral  = (blue_diff == SAMPLE_W'(CHROMA_MID)) && (red_diff == SAMPLE_W'(CHROMA_MID));
  assign gray     = (red == green) && (green == blue);
  assign gray_due = took && neutral;

  // Every accepted transaction yields a result once it has passed the input and result registers.
  `YRC_ASSERT_NXT(a_result_follows, took, ##1 done, "accepted pixel gave no result")
  // No result appears without an accepted transaction that passed both registers.
  `YRC_ASSERT_IMP(a_no_spurious, done, $past(took, 2), "result without an accepted pixel")
  // The frame-end mark travels with its pixel.
  `YRC_ASSERT_IMP(a_frame_mark, done, frame_last == $past(frame_end, 2), "frame mark lost")
  // Zero chroma gives a gray pixel.
  `YRC_ASSERT_IMP(a_gray, done && $past(gray_due, 2), gray, "neutral chroma not gray")

endmodule

bind ycbcr_to_rgb_converter_core yrc_checker u_yrc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .blue_diff  (blue_diff),
  .red_diff   (red_diff),
  .frame_end  (frame_end),
  .done       (done),
  .red        (red),
  .green      (green),
  .blue       (blue),
  .frame_last (frame_last)
);

`default_nettype wire
